@@ design/cfsd_pkg.sv @@
// Shared types, codes and constants of the camera frame stream deframer.
// No dependencies; the cfsd_* modules and the top level refer to it by scoped names.
package cfsd_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_SESSION = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_HDR       = 3'd0;
    localparam logic [2:0] ST_PAYLOAD   = 3'd1;
    localparam logic [2:0] ST_END       = 3'd2;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd3;
    localparam logic [2:0] ST_BAD_LEN   = 3'd4;
    localparam logic [2:0] ST_LINK      = 3'd5;
    localparam logic [2:0] ST_IGNORED   = 3'd6;
    localparam logic [2:0] ST_SESSION   = 3'd7;

    localparam int SIG_LEN = 9;
    localparam int HDR_LEN = 12;
    localparam int LEN_BYTES = 4;

    localparam int CNT_W = 24;
    localparam int MAX_LEN_W = 24;

    // Largest signed 64-bit value, the reset value of the clock offset.
    localparam logic [63:0] MAX_S64 = 64'h7FFF_FFFF_FFFF_FFFF;

    // One classified transaction, handed from the front to the back.
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_sequence;
        logic [31:0] frame_length;
        logic [63:0] sender_ticks;
        logic [62:0] header_start_time;
        logic [62:0] arrival_time;
    } t_cmd;

    // Session signature bytes.
    function automatic logic [7:0] magic_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0: v = 8'h42;
            4'd1: v = 8'h54;
            4'd2: v = 8'h4D;
            4'd3: v = 8'h4A;
            4'd4: v = 8'h50;
            4'd5: v = 8'h45;
            4'd6: v = 8'h47;
            4'd7: v = 8'h31;
            4'd8: v = 8'h0A;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ design/cfsd_in_if.sv @@
// Input stream channel: valid, ready and one received item.
// Depends on nothing.
interface cfsd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [62:0] arrival_time;

    modport source(output valid, output opcode, output data_byte, output arrival_time,
                   input ready);
    modport sink(input valid, input opcode, input data_byte, input arrival_time,
                 output ready);
endinterface

@@ design/cfsd_out_if.sv @@
// Result stream channel: valid, ready and one result item.
// Depends on nothing.
interface cfsd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [7:0]         payload_byte;
    logic               last_of_frame;
    logic signed [63:0] frame_timestamp;
    logic [31:0]        frame_sequence;
    logic [31:0]        frame_length;

    modport source(output valid, output status, output payload_byte, output last_of_frame,
                   output frame_timestamp, output frame_sequence, output frame_length,
                   input ready);
    modport sink(input valid, input status, input payload_byte, input last_of_frame,
                 input frame_timestamp, input frame_sequence, input frame_length,
                 output ready);
endinterface

@@ design/cfsd_front.sv @@
// Front end: accepts input transactions, tracks session and frame framing and
// classifies each byte into a command. Depends on cfsd_pkg and cfsd_in_if.
module cfsd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfsd_pkg::MAX_LEN_W-1:0] i_cfg_data,
    cfsd_in_if.sink                        i_in,
    input  logic                           i_q_full,
    output logic                           o_push,
    output cfsd_pkg::t_cmd                 o_cmd
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIG  = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_BODY = 3'd3;
    localparam logic [2:0] PH_DEAD = 3'd4;

    localparam int CW = cfsd_pkg::CNT_W;

    logic [cfsd_pkg::MAX_LEN_W-1:0] r_max_len;
    logic [2:0]   r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]  r_length, n_length;
    logic [63:0]  r_ticks, n_ticks;
    logic [62:0]  r_hst, n_hst;
    logic [31:0]  r_frames, n_frames;
    logic [CW-1:0] cnt_inc;
    logic          accept;
    cfsd_pkg::t_cmd cmd;

    assign i_in.ready = !i_q_full;
    assign accept = i_in.valid && i_in.ready;
    assign cnt_inc = r_cnt + CW'(1);

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_length = r_length;
        n_ticks  = r_ticks;
        n_hst    = r_hst;
        n_frames = r_frames;

        cmd                   = '0;
        cmd.status            = cfsd_pkg::ST_IGNORED;
        cmd.sender_ticks      = r_ticks;
        cmd.header_start_time = r_hst;
        cmd.arrival_time      = i_in.arrival_time;

        case (i_in.opcode)
            cfsd_pkg::OP_SESSION: begin
                n_phase    = PH_SIG;
                n_cnt      = '0;
                cmd.status = cfsd_pkg::ST_SESSION;
            end
            cfsd_pkg::OP_STOP: begin
                n_phase    = PH_IDLE;
                n_cnt      = '0;
                cmd.status = cfsd_pkg::ST_LINK;
            end
            cfsd_pkg::OP_DATA: begin
                case (r_phase)
                    PH_SIG: begin
                        if (i_in.data_byte != cfsd_pkg::magic_byte(r_cnt[3:0])) begin
                            n_phase    = PH_DEAD;
                            cmd.status = cfsd_pkg::ST_BAD_MAGIC;
                        end else begin
                            cmd.status = cfsd_pkg::ST_HDR;
                            if (r_cnt == CW'(cfsd_pkg::SIG_LEN - 1)) begin
                                n_phase = PH_HDR;
                                n_cnt   = '0;
                            end else begin
                                n_cnt = cnt_inc;
                            end
                        end
                    end
                    PH_HDR: begin
                        cmd.status = cfsd_pkg::ST_HDR;
                        if (r_cnt == '0) begin
                            n_hst = i_in.arrival_time;
                        end
                        if (r_cnt < CW'(cfsd_pkg::LEN_BYTES)) begin
                            n_length = {r_length[23:0], i_in.data_byte};
                        end else begin
                            n_ticks = {r_ticks[55:0], i_in.data_byte};
                        end
                        if (r_cnt == CW'(cfsd_pkg::HDR_LEN - 1)) begin
                            // The length field is complete well before the last header byte.
                            n_cnt = '0;
                            if (r_length == '0 || r_length > {8'd0, r_max_len}) begin
                                n_phase          = PH_DEAD;
                                cmd.status       = cfsd_pkg::ST_BAD_LEN;
                                cmd.frame_length = r_length;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    PH_BODY: begin
                        cmd.payload_byte = i_in.data_byte;
                        // In a body the length is nonzero and fits the counter.
                        if (cnt_inc == r_length[CW-1:0]) begin
                            n_frames           = r_frames + 32'd1;
                            cmd.status         = cfsd_pkg::ST_END;
                            cmd.last_of_frame  = 1'b1;
                            cmd.frame_sequence = n_frames;
                            cmd.frame_length   = r_length;
                            n_phase            = PH_HDR;
                            n_cnt              = '0;
                        end else begin
                            cmd.status = cfsd_pkg::ST_PAYLOAD;
                            n_cnt      = cnt_inc;
                        end
                    end
                    default: begin
                        cmd.status = cfsd_pkg::ST_IGNORED;
                    end
                endcase
            end
            default: begin
                cmd.status = cfsd_pkg::ST_IGNORED;
            end
        endcase
    end

    assign o_push = accept;
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 24'd1048576;
            r_phase   <= PH_IDLE;
            r_cnt     <= '0;
            r_length  <= '0;
            r_ticks   <= '0;
            r_hst     <= '0;
            r_frames  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_length <= n_length;
                r_ticks  <= n_ticks;
                r_hst    <= n_hst;
                r_frames <= n_frames;
            end
        end
    end

endmodule

@@ design/cfsd_queue.sv @@
// Short command queue between front and back end.
// Depends on cfsd_pkg for the command type.
module cfsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfsd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output cfsd_pkg::t_cmd o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfsd_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

@@ design/cfsd_back.sv @@
// Back end: maps sender capture ticks to local time at frame end and drives the
// result channel through a two-stage pipeline. Depends on cfsd_pkg and cfsd_out_if.
module cfsd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  cfsd_pkg::t_cmd i_q_head,
    output logic           o_pop,
    cfsd_out_if.source     o_out
);

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic        last_of_frame;
        logic [31:0] frame_sequence;
        logic [31:0] frame_length;
        logic [62:0] header_start_time;
        logic [62:0] arrival_time;
        logic        tick_ok;
        logic        take_now;
        logic [63:0] sum;
    } t_stage;

    logic [63:0] r_off;
    logic        r_off_valid;
    logic        r_s1_valid;
    t_stage      r_s1, n_s1;
    logic        r_o_valid;
    logic [2:0]  r_o_status;
    logic [7:0]  r_o_byte;
    logic        r_o_last;
    logic [63:0] r_o_ts, n_ts;
    logic [31:0] r_o_seq;
    logic [31:0] r_o_len;

    logic        out_adv, s1_adv;
    logic [63:0] now64, seen;
    logic        is_end, upd;

    assign out_adv = !r_o_valid || o_out.ready;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = i_q_valid && s1_adv;

    assign now64  = {1'b0, i_q_head.arrival_time};
    assign seen   = now64 - i_q_head.sender_ticks;
    assign is_end = (i_q_head.status == cfsd_pkg::ST_END);

    always_comb begin
        n_s1.status            = i_q_head.status;
        n_s1.payload_byte      = i_q_head.payload_byte;
        n_s1.last_of_frame     = i_q_head.last_of_frame;
        n_s1.frame_sequence    = i_q_head.frame_sequence;
        n_s1.frame_length      = i_q_head.frame_length;
        n_s1.header_start_time = i_q_head.header_start_time;
        n_s1.arrival_time      = i_q_head.arrival_time;
        n_s1.tick_ok  = (i_q_head.sender_ticks != '0) && !i_q_head.sender_ticks[63];
        // A smaller offset maps the tick exactly onto the arrival time.
        n_s1.take_now = !r_off_valid || ($signed(seen) < $signed(r_off));
        n_s1.sum      = i_q_head.sender_ticks + r_off;
    end

    assign upd = o_pop && is_end && n_s1.tick_ok && n_s1.take_now;

    always_comb begin
        if (r_s1.status != cfsd_pkg::ST_END) begin
            n_ts = '0;
        end else if (!r_s1.tick_ok) begin
            n_ts = {1'b0, r_s1.header_start_time};
        end else if (r_s1.take_now) begin
            n_ts = {1'b0, r_s1.arrival_time};
        end else if ($signed({1'b0, r_s1.arrival_time}) < $signed(r_s1.sum)) begin
            n_ts = {1'b0, r_s1.arrival_time};
        end else begin
            n_ts = r_s1.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= n_s1;
        end
        if (out_adv) begin
            r_o_status <= r_s1.status;
            r_o_byte   <= r_s1.payload_byte;
            r_o_last   <= r_s1.last_of_frame;
            r_o_ts     <= n_ts;
            r_o_seq    <= r_s1.frame_sequence;
            r_o_len    <= r_s1.frame_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off       <= cfsd_pkg::MAX_S64;
            r_off_valid <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (upd) begin
                r_off       <= seen;
                r_off_valid <= 1'b1;
            end
            if (s1_adv) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.status          = r_o_status;
    assign o_out.payload_byte    = r_o_byte;
    assign o_out.last_of_frame   = r_o_last;
    assign o_out.frame_timestamp = $signed(r_o_ts);
    assign o_out.frame_sequence  = r_o_seq;
    assign o_out.frame_length    = r_o_len;

    // Once an offset has been observed it is never forgotten.
    a_off_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off_valid |=> r_off_valid)
        else $error("clock offset lost its valid flag");

    // The tracked offset only ever moves down.
    a_off_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off_valid |=> ($signed(r_off) <= $signed($past(r_off))))
        else $error("clock offset increased");

    // Only a frame end carries a timestamp.
    a_ts_end_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status != cfsd_pkg::ST_END)) |-> (o_out.frame_timestamp == '0))
        else $error("timestamp on a result that is not a frame end");

endmodule

@@ design/camera_frame_stream_deframer_core.sv @@
// Top level of the camera frame stream deframer: front end, command queue and
// back end. Depends on cfsd_pkg, cfsd_in_if, cfsd_out_if and the cfsd_* modules.
//
// The block takes one input transaction per clock cycle while its queue is not full and
// returns exactly one result transaction for each, in order. The command waits in the
// queue, then passes the first back-end stage (offset compare) into the output
// register (clamp against the arrival time), where the capture tick is mapped to
// local time. The queue of QUEUE_DEPTH entries lets input continue while results
// wait; input ready drops only when the queue is full. max_frame_bytes is written
// through i_cfg_we and i_cfg_data and resets to 1048576.
module camera_frame_stream_deframer_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cfsd_pkg::MAX_LEN_W-1:0] i_cfg_data,
    cfsd_in_if.sink                        i_in,
    cfsd_out_if.source                     o_out
);

    logic           q_full, q_valid, push, pop;
    cfsd_pkg::t_cmd push_cmd, head_cmd;

    cfsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    cfsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    cfsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (head_cmd),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for camera_frame_stream_deframer_core.
// Depends on cfsd_pkg, cfsd_in_if, cfsd_out_if and the design files; a scoreboard
// class predicts every result of the byte stream and checks the DUT against it.
`timescale 1ns / 100ps

typedef enum logic [2:0] {
    WAIT_SESSION,
    IN_MAGIC,
    IN_HEADER,
    IN_BODY,
    DEAD
} t_deframe_phase;

typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic [63:0] frame_timestamp;
    logic [31:0] frame_sequence;
    logic [31:0] frame_length;
} t_frame_result;

class deframe_tracker;
    t_frame_result  expected_q[$];
    t_deframe_phase phase;
    logic [31:0]    byte_count;
    logic [31:0]    length_field;
    logic [63:0]    sender_ticks;
    logic [63:0]    header_start;
    logic [63:0]    clock_offset;
    bit             offset_ok;
    logic [31:0]    frames_done;
    logic [23:0]    max_len;
    logic [7:0]     magic[cfsd_pkg::SIG_LEN];
    int             errors;
    int             results_seen;

    function new();
        magic        = '{8'h42, 8'h54, 8'h4D, 8'h4A, 8'h50, 8'h45, 8'h47, 8'h31, 8'h0A};
        max_len      = 24'h10_0000;
        phase        = WAIT_SESSION;
        byte_count   = '0;
        length_field = '0;
        sender_ticks = '0;
        header_start = '0;
        clock_offset = cfsd_pkg::MAX_S64;
        offset_ok    = 1'b0;
        frames_done  = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Maps a valid sender tick to local time through the smallest offset so far.
    function logic [63:0] local_capture_time(logic [63:0] now);
        logic [63:0] seen;
        logic [63:0] t;
        if (sender_ticks == 64'd0 || sender_ticks[63])
            return header_start;
        seen = now - sender_ticks;
        if (!offset_ok || $signed(seen) < $signed(clock_offset)) begin
            clock_offset = seen;
            offset_ok    = 1'b1;
        end
        t = sender_ticks + clock_offset;
        if ($signed(now) < $signed(t))
            t = now;
        return t;
    endfunction

    // Notes one accepted input transaction and queues the result it causes.
    function logic [2:0] take_item(logic [1:0] op, logic [7:0] b, logic [62:0] at);
        t_frame_result r;
        logic [63:0]   now;
        r        = '0;
        r.status = cfsd_pkg::ST_IGNORED;
        now      = {1'b0, at};
        if (op == cfsd_pkg::OP_SESSION) begin
            phase      = IN_MAGIC;
            byte_count = '0;
            r.status   = cfsd_pkg::ST_SESSION;
        end else if (op == cfsd_pkg::OP_STOP) begin
            phase      = WAIT_SESSION;
            byte_count = '0;
            r.status   = cfsd_pkg::ST_LINK;
        end else if (op == cfsd_pkg::OP_DATA) begin
            case (phase)
                IN_MAGIC: begin
                    if (byte_count >= cfsd_pkg::SIG_LEN || b != magic[byte_count]) begin
                        phase    = DEAD;
                        r.status = cfsd_pkg::ST_BAD_MAGIC;
                    end else begin
                        r.status   = cfsd_pkg::ST_HDR;
                        byte_count = byte_count + 1;
                        if (byte_count == cfsd_pkg::SIG_LEN) begin
                            phase      = IN_HEADER;
                            byte_count = '0;
                        end
                    end
                end
                IN_HEADER: begin
                    r.status = cfsd_pkg::ST_HDR;
                    if (byte_count == 0)
                        header_start = now;
                    if (byte_count < cfsd_pkg::LEN_BYTES)
                        length_field = {length_field[23:0], b};
                    else
                        sender_ticks = {sender_ticks[55:0], b};
                    byte_count = byte_count + 1;
                    if (byte_count >= cfsd_pkg::HDR_LEN) begin
                        byte_count = '0;
                        if (length_field == 0 || length_field > {8'h00, max_len}) begin
                            phase          = DEAD;
                            r.status       = cfsd_pkg::ST_BAD_LEN;
                            r.frame_length = length_field;
                        end else begin
                            phase = IN_BODY;
                        end
                    end
                end
                IN_BODY: begin
                    r.payload_byte = b;
                    byte_count     = byte_count + 1;
                    if (byte_count >= length_field) begin
                        frames_done       = frames_done + 1;
                        r.status          = cfsd_pkg::ST_END;
                        r.last_of_frame   = 1'b1;
                        r.frame_sequence  = frames_done;
                        r.frame_length    = length_field;
                        r.frame_timestamp = local_capture_time(now);
                        phase             = IN_HEADER;
                        byte_count        = '0;
                    end else begin
                        r.status = cfsd_pkg::ST_PAYLOAD;
                    end
                end
                default: ;
            endcase
        end
        expected_q.push_back(r);
        return r.status;
    endfunction

    task report(string what, logic [63:0] want, logic [63:0] got);
        errors++;
        if (errors <= 100)
            $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, what, want, got);
    endtask

    task check_result(t_frame_result got);
        t_frame_result want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report("result with nothing outstanding, status", 64'd0, 64'(got.status));
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status)
            report("status", 64'(want.status), 64'(got.status));
        if (got.payload_byte !== want.payload_byte)
            report("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
        if (got.last_of_frame !== want.last_of_frame)
            report("last_of_frame", 64'(want.last_of_frame), 64'(got.last_of_frame));
        if (got.frame_timestamp !== want.frame_timestamp)
            report("frame_timestamp", want.frame_timestamp, got.frame_timestamp);
        if (got.frame_sequence !== want.frame_sequence)
            report("frame_sequence", 64'(want.frame_sequence), 64'(got.frame_sequence));
        if (got.frame_length !== want.frame_length)
            report("frame_length", 64'(want.frame_length), 64'(got.frame_length));
    endtask
endclass

module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int END_WAIT        = 8;
    localparam int ITEMS_PER_PHASE = 340;
    localparam int NUM_PHASES      = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [23:0] cfg_data;

    cfsd_in_if  in_ch();
    cfsd_out_if out_ch();

    camera_frame_stream_deframer_core DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    deframe_tracker sb;
    logic [62:0]    clock_now;
    int             counted_items;
    int             src_mode;
    int             src_items;
    logic [23:0]    limits[NUM_PHASES];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mode 0 never idles, mode 1 idles over the full range, mode 2 now and then.
    function automatic int draw_gap(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return $urandom_range(0, 17);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endfunction

    function automatic logic [62:0] next_arrival();
        logic [62:0] t;
        t = clock_now;
        if ($urandom_range(0, 299) == 0)
            clock_now = {31'($urandom), 32'($urandom)};
        else
            clock_now = clock_now + 63'($urandom_range(1, 40));
        return t;
    endfunction

    function automatic logic [63:0] pick_ticks();
        logic [63:0] t;
        case ($urandom_range(0, 9))
            0:       t = 64'd0;
            1:       t = {1'b1, 31'($urandom), 32'($urandom)};
            2:       t = cfsd_pkg::MAX_S64;
            3:       t = {32'($urandom), 32'($urandom)};
            4:       t = 64'd1;
            default: t = {1'b0, clock_now} + 64'($urandom_range(0, 1000)) - 64'd500;
        endcase
        return t;
    endfunction

    function automatic logic [31:0] pick_length();
        logic [31:0] n;
        case ($urandom_range(0, 19))
            0: n = 32'd0;
            1: n = {8'h00, sb.max_len} + 32'd1;
            2: n = $urandom;
            3: n = (sb.max_len != 0 && sb.max_len <= 64) ? {8'h00, sb.max_len}
                                                          : 32'($urandom_range(1, 6));
            default: n = $urandom_range(1, 6);
        endcase
        return n;
    endfunction

    task automatic send(input logic [1:0] op, input logic [7:0] b);
        int          gap;
        logic [62:0] at;
        logic [2:0]  st;
        gap = draw_gap(src_mode);
        src_items++;
        if (src_items % 40 == 0)
            src_mode = $urandom_range(0, 2);
        at = next_arrival();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.data_byte    <= b;
        in_ch.arrival_time <= at;
        do @(posedge clk); while (!in_ch.ready);
        st = sb.take_item(op, b, at);
        if (st != cfsd_pkg::ST_IGNORED)
            counted_items++;
    endtask

    task automatic send_header(input logic [31:0] len, input logic [63:0] ticks);
        logic [95:0] hdr;
        hdr = {len, ticks};
        for (int i = 0; i < cfsd_pkg::HDR_LEN; i++)
            send(cfsd_pkg::OP_DATA, hdr[95 - 8 * i -: 8]);
    endtask

    task automatic send_frame();
        logic [31:0] len;
        int          npay;
        len = pick_length();
        send_header(len, pick_ticks());
        if (sb.phase != IN_BODY)
            return;
        // Long frames are cut short; a few short ones too, to exercise abandonment.
        if (len > 64)
            npay = $urandom_range(1, 20);
        else if ($urandom_range(0, 11) == 0)
            npay = $urandom_range(0, int'(len) - 1);
        else
            npay = int'(len);
        for (int i = 0; i < npay; i++)
            send(cfsd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_session();
        int          nframes;
        int          k;
        logic [7:0]  b;
        send(cfsd_pkg::OP_SESSION, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, cfsd_pkg::SIG_LEN - 1);
            for (int i = 0; i < k; i++)
                send(cfsd_pkg::OP_DATA, sb.magic[i]);
            b = 8'($urandom_range(0, 255));
            if (b == sb.magic[k])
                b = b ^ 8'h01;
            send(cfsd_pkg::OP_DATA, b);
            repeat ($urandom_range(0, 3)) send(cfsd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
            return;
        end
        for (int i = 0; i < cfsd_pkg::SIG_LEN; i++)
            send(cfsd_pkg::OP_DATA, sb.magic[i]);
        nframes = $urandom_range(1, 6);
        for (int f = 0; f < nframes; f++) begin
            send_frame();
            if (sb.phase != IN_HEADER)
                break;
        end
        if ($urandom_range(0, 2) == 0)
            send(cfsd_pkg::OP_STOP, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    // Stops the input side and waits until every expected result has come back.
    task automatic settle();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [23:0] v);
        cfg_we     <= 1'b1;
        cfg_data   <= v;
        sb.max_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        sb = new();
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_data           <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.opcode       <= cfsd_pkg::OP_DATA;
        in_ch.data_byte    <= '0;
        in_ch.arrival_time <= '0;
        counted_items = 0;
        src_items     = 0;
        src_mode      = 1;
        clock_now     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Data outside a session, the unused opcode and a stop while idle.
        send(cfsd_pkg::OP_DATA, 8'hFF);
        send(OP_UNUSED, 8'h00);
        send(cfsd_pkg::OP_STOP, 8'h00);
        // Signature wrong at its first byte, then a clean session.
        send(cfsd_pkg::OP_SESSION, 8'h00);
        send(cfsd_pkg::OP_DATA, 8'h00);
        send(cfsd_pkg::OP_SESSION, 8'hFF);
        for (int i = 0; i < cfsd_pkg::SIG_LEN; i++)
            send(cfsd_pkg::OP_DATA, sb.magic[i]);
        // One-byte frame with a zero sender tick, header started at the latest time.
        clock_now = '1;
        send_header(32'd1, 64'd0);
        send(cfsd_pkg::OP_DATA, 8'h00);

        limits = '{24'hFF_FFFF, 24'd1, 24'd0, 24'($urandom_range(2, 16)), 24'($urandom),
                   24'd6};
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_limit(limits[p]);
            while (counted_items < (p + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    run_session();
            end
        end

        settle();
        repeat (END_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_frame_result got;
        int            gap;
        int            taken;
        int            sink_mode;
        out_ch.ready <= 1'b0;
        taken     = 0;
        sink_mode = 1;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = draw_gap(sink_mode);
            taken++;
            if (taken % 40 == 0)
                sink_mode = $urandom_range(0, 2);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.status          = out_ch.status;
            got.payload_byte    = out_ch.payload_byte;
            got.last_of_frame   = out_ch.last_of_frame;
            got.frame_timestamp = out_ch.frame_timestamp;
            got.frame_sequence  = out_ch.frame_sequence;
            got.frame_length    = out_ch.frame_length;
            sb.check_result(got);
        end
    end

    // Ends the run when no transaction has been accepted on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end
endmodule
